// ===== sv/spq_pkg.sv =====
package spq_pkg;

   localparam int KEY_W        = 32;
   localparam int OCC_W        = 4;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int CAPACITY_DEF = 8;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Controller to datapath: commit one operation.
   typedef struct packed {
      logic                load;
      logic                push;
      logic                pop;
      logic [STATUS_W-1:0] status;
   } ctl_cmd_type;

   // Datapath to controller: occupancy state.
   typedef struct packed {
      logic full;
      logic empty;
   } dp_stat_type;

endpackage

// ===== sv/spq_ctrl.sv =====
module spq_ctrl
   import spq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dp_stat_type       dp_stat,
   output ctl_cmd_type       ctl
);

   typedef enum logic {
      ST_IDLE,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // A waiting result that leaves this cycle frees the output register.
   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_HOLD);

   always_comb begin
      ctl.load   = accept;
      ctl.push   = 1'b0;
      ctl.pop    = 1'b0;
      ctl.status = STATUS_DONE;
      unique case (req_cmd)
         CMD_INSERT: begin
            if (dp_stat.full) begin
               ctl.status = STATUS_FULL;
            end else begin
               ctl.push = accept;
            end
         end
         CMD_REMOVE: begin
            if (dp_stat.empty) begin
               ctl.status = STATUS_EMPTY;
            end else begin
               ctl.pop = accept;
            end
         end
         default: begin
            // query and the unused code change nothing
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_ready && !accept) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/spq_dpath.sv =====
module spq_dpath
   import spq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [KEY_W-1:0]    req_value,
   input  ctl_cmd_type                ctl,
   output dp_stat_type                dp_stat,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [KEY_W-1:0]    rsp_head_value,
   output logic [OCC_W-1:0]           rsp_occupancy,
   output logic                       rsp_empty_flag,
   output logic                       rsp_full_flag
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [KEY_W-1:0] entry_ff [CAPACITY];
   logic signed [KEY_W-1:0] entry_in [CAPACITY];
   logic [CAPACITY-1:0]     move;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic [STATUS_W-1:0]     status_ff;
   logic signed [KEY_W-1:0] head_ff, head_in;
   logic [OCC_W-1:0]        occ_ff;
   logic                    empty_ff, full_ff;

   assign dp_stat.full  = (count_ff == CNT_W'(CAPACITY));
   assign dp_stat.empty = (count_ff == '0);

   // Each cell compares its key with the new one; a cell moves aside when it
   // holds a strictly greater key or lies past the last stored entry.
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         assign move[gi] = (CNT_W'(gi) >= count_ff) || (entry_ff[gi] > req_value);

         if (gi == 0) begin : g_first
            always_comb begin
               if (ctl.pop) begin
                  entry_in[gi] = (CAPACITY > 1) ? entry_ff[gi+1] : entry_ff[gi];
               end else if (ctl.push && move[gi]) begin
                  entry_in[gi] = req_value;
               end else begin
                  entry_in[gi] = entry_ff[gi];
               end
            end
         end else if (gi == CAPACITY - 1) begin : g_last
            always_comb begin
               if (ctl.push && move[gi]) begin
                  entry_in[gi] = move[gi-1] ? entry_ff[gi-1] : req_value;
               end else begin
                  entry_in[gi] = entry_ff[gi];
               end
            end
         end else begin : g_mid
            always_comb begin
               if (ctl.pop) begin
                  entry_in[gi] = entry_ff[gi+1];
               end else if (ctl.push && move[gi]) begin
                  entry_in[gi] = move[gi-1] ? entry_ff[gi-1] : req_value;
               end else begin
                  entry_in[gi] = entry_ff[gi];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (ctl.push || ctl.pop) entry_ff[gi] <= entry_in[gi];
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      head_in = (count_in != '0) ? entry_in[0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         status_ff <= ctl.status;
         head_ff   <= head_in;
         occ_ff    <= OCC_W'(count_in);
         empty_ff  <= (count_in == '0);
         full_ff   <= (count_in == CNT_W'(CAPACITY));
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_head_value = head_ff;
   assign rsp_occupancy  = occ_ff;
   assign rsp_empty_flag = empty_ff;
   assign rsp_full_flag  = full_ff;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Latency: a result is valid in the cycle after its request transfer.
// Throughput: one operation per cycle while rsp_ready is high; the sorted
// cell row compares and shifts all entries at once, so the next request
// transfers together with the transfer of the waiting result.
// Reset (synchronous, active high) empties the queue and drops any waiting
// result; the key cells are not cleared.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic signed [KEY_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic signed [KEY_W-1:0] rsp_head_value,
   output logic [OCC_W-1:0]        rsp_occupancy,
   output logic                    rsp_empty_flag,
   output logic                    rsp_full_flag
);

   ctl_cmd_type ctl;
   dp_stat_type dp_stat;

   // Controller: handshake, command decode and full/empty rejection.
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .ctl       (ctl)
   );

   // Datapath: the ascending key cells, the count and the result register.
   spq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .ctl            (ctl),
      .dp_stat        (dp_stat),
      .rsp_status     (rsp_status),
      .rsp_head_value (rsp_head_value),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_empty_flag (rsp_empty_flag),
      .rsp_full_flag  (rsp_full_flag)
   );

endmodule

// ===== sv/spq_checker.sv =====
module spq_checker
   import spq_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic signed [KEY_W-1:0] rsp_head_value,
   input logic [OCC_W-1:0]        rsp_occupancy,
   input logic                    rsp_empty_flag,
   input logic                    rsp_full_flag
);

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_flag |-> rsp_head_value == '0 && rsp_occupancy == '0)
      else $error("empty result with nonzero head or occupancy");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_full_flag)
      else $error("insert rejected while queue not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_empty_flag && !rsp_full_flag)
      else $error("remove rejected while queue not empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_head_value))
      else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_head_value (rsp_head_value),
   .rsp_occupancy  (rsp_occupancy),
   .rsp_empty_flag (rsp_empty_flag),
   .rsp_full_flag  (rsp_full_flag)
);

// ===== tb/sv/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int CAPACITY        = CAPACITY_DEF;
   localparam int RANDOM_ITEMS    = 1275;
   localparam int IDLE_LIMIT      = 4000;  // cycles with no transfer on either channel
   localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
   localparam int HOLD_AFTER_REQS = 400;
   localparam int DRAIN_CYCLES    = 4;
   localparam int MAX_PRINTS      = 40;

   // Code 3 is not a named command; the block treats it as a query.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [KEY_W-1:0] head_value;
      logic [OCC_W-1:0]        occupancy;
      logic                    empty_flag;
      logic                    full_flag;
   } qresult_type;

   // One directed row: a request plus, where obvious, the result typed in.
   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic signed [KEY_W-1:0] value;
      logic                    known;
      qresult_type             known_res;
   } stim_row_type;

   localparam qresult_type NO_RES  = '0;
   localparam qresult_type IDLE_Q  = '{STATUS_DONE, 32'sd0, 4'd0, 1'b1, 1'b0};
   localparam int          N_ROWS  = 25;

   // Walk the extremes, fill to capacity, overflow, drain past empty.
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{CMD_QUERY,  32'sh0000_0000, 1'b1, IDLE_Q},
      '{CMD_REMOVE, 32'sh0000_0000, 1'b1, '{STATUS_EMPTY, 32'sd0, 4'd0, 1'b1, 1'b0}},
      '{CMD_UNUSED, 32'shFFFF_FFFF, 1'b1, IDLE_Q},
      '{CMD_INSERT, 32'sh7FFF_FFFF, 1'b1, '{STATUS_DONE, 32'sh7FFF_FFFF, 4'd1, 1'b0, 1'b0}},
      '{CMD_INSERT, 32'sh8000_0000, 1'b1, '{STATUS_DONE, 32'sh8000_0000, 4'd2, 1'b0, 1'b0}},
      '{CMD_INSERT, 32'sh0000_0000, 1'b0, NO_RES},
      '{CMD_INSERT, 32'shFFFF_FFFF, 1'b0, NO_RES},
      '{CMD_INSERT, 32'sh0000_0001, 1'b0, NO_RES},
      '{CMD_INSERT, 32'sh0000_0000, 1'b0, NO_RES},
      '{CMD_INSERT, 32'sh8000_0000, 1'b0, NO_RES},
      '{CMD_INSERT, 32'sh5555_5555, 1'b0, NO_RES},
      '{CMD_INSERT, 32'shAAAA_AAAA, 1'b1, '{STATUS_FULL, 32'sh8000_0000, 4'd8, 1'b0, 1'b1}},
      '{CMD_QUERY,  32'shAAAA_AAAA, 1'b0, NO_RES},
      '{CMD_UNUSED, 32'sh5555_5555, 1'b0, NO_RES},
      '{CMD_REMOVE, 32'sh0000_0000, 1'b0, NO_RES},
      '{CMD_REMOVE, 32'sh0000_0000, 1'b0, NO_RES},
      '{CMD_REMOVE, 32'sh0000_0000, 1'b0, NO_RES},
      '{CMD_REMOVE, 32'sh0000_0000, 1'b0, NO_RES},
      '{CMD_REMOVE, 32'sh0000_0000, 1'b0, NO_RES},
      '{CMD_REMOVE, 32'sh0000_0000, 1'b0, NO_RES},
      '{CMD_REMOVE, 32'sh0000_0000, 1'b0, NO_RES},
      '{CMD_REMOVE, 32'sh0000_0000, 1'b0, NO_RES},
      '{CMD_REMOVE, 32'sh0000_0000, 1'b1, '{STATUS_EMPTY, 32'sd0, 4'd0, 1'b1, 1'b0}},
      '{CMD_INSERT, 32'shFFFF_FFFF, 1'b1, '{STATUS_DONE, 32'shFFFF_FFFF, 4'd1, 1'b0, 1'b0}},
      '{CMD_REMOVE, 32'sh0000_0000, 1'b1, IDLE_Q}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [CMD_W-1:0]        req_cmd = CMD_QUERY;
   logic signed [KEY_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic signed [KEY_W-1:0] rsp_head_value;
   logic [OCC_W-1:0]        rsp_occupancy;
   logic                    rsp_empty_flag;
   logic                    rsp_full_flag;

   // Travel with the request: a typed-in result for directed rows.
   logic                    row_known = 1'b0;
   qresult_type             row_known_res = '0;

   int                      mismatch_count = 0;
   int                      req_transfers = 0;
   int                      burst_left = 0;
   bit                      hold_done = 1'b0;
   qresult_type             expected_results [$];

   // Predictor state: ascending keys and their count.
   logic signed [KEY_W-1:0] sorted_keys [CAPACITY];
   int                      key_count = 0;

   sorted_priority_queue #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_head_value(rsp_head_value),
      .rsp_occupancy (rsp_occupancy),
      .rsp_empty_flag(rsp_empty_flag),
      .rsp_full_flag (rsp_full_flag)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one operation to the predicted queue and return the result it reports.
   function automatic qresult_type apply_queue_op(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [KEY_W-1:0] key);
      qresult_type res;
      int          pos;
      res.status = STATUS_DONE;
      if (cmd == CMD_INSERT) begin
         if (key_count >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            // Shift strictly greater keys up so equal keys keep arrival order.
            pos = key_count;
            while (pos > 0 && sorted_keys[pos-1] > key) begin
               sorted_keys[pos] = sorted_keys[pos-1];
               pos--;
            end
            sorted_keys[pos] = key;
            key_count++;
         end
      end else if (cmd == CMD_REMOVE) begin
         if (key_count == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            for (int i = 1; i < key_count; i++)
               sorted_keys[i-1] = sorted_keys[i];
            key_count--;
         end
      end
      res.head_value = (key_count > 0) ? sorted_keys[0] : '0;
      res.occupancy  = key_count[OCC_W-1:0];
      res.empty_flag = (key_count == 0);
      res.full_flag  = (key_count == CAPACITY);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                  input logic [KEY_W-1:0] want);
      if (mismatch_count < MAX_PRINTS)
         $display("%0t: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Offer one request, hold it until it transfers, then maybe idle for a gap.
   task automatic offer_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [KEY_W-1:0] value,
                                input logic known, input qresult_type known_res);
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_value     <= value;
      row_known     <= known;
      row_known_res <= known_res;
      do @(posedge clock); while (!(req_valid && req_ready));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // End of burst: drop valid for a gap, then pick the next burst length.
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 24);
      end
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9)) inside
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         [2:4]:   return $signed(32'($urandom_range(0, 8))) - 32'sd4;  // crowd duplicates
         default: return $urandom;
      endcase
   endfunction

   // Sender: directed table first, then random phases that lean toward
   // filling, draining or holding level so both full and empty get reached.
   initial begin
      int               insert_pct;
      int               phase_left;
      int               roll;
      logic [CMD_W-1:0] cmd;
      insert_pct = 50;
      phase_left = 0;
      wait (!reset);
      @(posedge clock);
      for (int r = 0; r < N_ROWS; r++)
         offer_request(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].value,
                       DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].known_res);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_pct = 75;
               1:       insert_pct = 25;
               default: insert_pct = 50;
            endcase
            phase_left = $urandom_range(10, 40);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 5)
            cmd = CMD_QUERY;
         else if (roll < 9)
            cmd = CMD_UNUSED;
         else if (roll < 9 + insert_pct * 91 / 100)
            cmd = CMD_INSERT;
         else
            cmd = CMD_REMOVE;
         offer_request(cmd, pick_key(), 1'b0, NO_RES);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("sorted_priority_queue_tb OK");
      else
         $display("sorted_priority_queue_tb NOT OK");
      $finish;
   end

   // Receiver: switch among random stall patterns; once, hold off long
   // enough for the block to fill and stall its request side.
   initial begin
      int          stall_mode;
      int unsigned rx_cycle;
      stall_mode = 0;
      rx_cycle   = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (!hold_done && req_transfers >= HOLD_AFTER_REQS) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
            rsp_ready <= 1'b1;
         end else begin
            if (rx_cycle % 64 == 0)
               stall_mode = $urandom_range(0, 3);
            case (stall_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ((rx_cycle & 7) < 5);
            endcase
         end
      end
   end

   // Checker: retire the oldest expectation on each result transfer, then
   // predict the result of any request transfer at the same edge.
   always @(posedge clock) begin
      qresult_type want;
      qresult_type pred;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_head_value, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", KEY_W'(rsp_status), KEY_W'(want.status));
               if (rsp_head_value !== want.head_value)
                  report_mismatch("head_value", rsp_head_value, want.head_value);
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch("occupancy", KEY_W'(rsp_occupancy),
                                  KEY_W'(want.occupancy));
               if (rsp_empty_flag !== want.empty_flag)
                  report_mismatch("empty_flag", KEY_W'(rsp_empty_flag),
                                  KEY_W'(want.empty_flag));
               if (rsp_full_flag !== want.full_flag)
                  report_mismatch("full_flag", KEY_W'(rsp_full_flag),
                                  KEY_W'(want.full_flag));
            end
         end
         if (req_valid && req_ready) begin
            pred = apply_queue_op(req_cmd, req_value);
            expected_results.push_back(row_known ? row_known_res : pred);
            req_transfers <= req_transfers + 1;
         end
      end
   end

   // Watchdog: end the run if neither channel transfers for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("sorted_priority_queue_tb NOT OK");
      $finish;
   end

endmodule
